// ----- design/ascii_dec_hex_converter_macros.svh -----
// ----------------------------------------------------------------------------
// ascii_dec_hex_converter_macros : assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASCII_DEC_HEX_CONVERTER_MACROS_SVH
`define ASCII_DEC_HEX_CONVERTER_MACROS_SVH

`ifndef SYNTH
`define ADHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adhc: same-cycle check failed");
`define ADHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adhc: next-cycle check failed");
`else
`define ADHC_ASSERT_SAME(label, clk, rst, ante, cons)
`define ADHC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/adhc_pkg.sv -----
// ----------------------------------------------------------------------------
// adhc_pkg : shared types and constants
// Value width, character codes and the engine command for the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package adhc_pkg;

   localparam int VALUE_BITS = 64;
   localparam int NBUF       = 20;
   localparam int PTR_W      = $clog2(NBUF);

   typedef logic [7:0]            char_type;
   typedef logic [3:0]            digit_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   localparam value_type VALUE_SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_NINE    = 8'h39;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_F = 8'h46;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_F = 8'h66;
   localparam char_type CHAR_LOWER_X = 8'h78;
   localparam char_type CHAR_MINUS   = 8'h2D;

   localparam digit_type RADIX_DEC = 4'd10;

   typedef struct packed {
      logic      start;
      logic      to_dec;
      value_type value;
   } conv_cmd_type;

endpackage

`default_nettype wire

// ----- design/adhc_req_if.sv -----
// ----------------------------------------------------------------------------
// adhc_req_if : character input channel
// Valid/ready channel carrying one token character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adhc_req_if ();
   import adhc_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;
   logic     token_end;

   modport source (output valid, output char_code, output token_end, input ready);
   modport sink   (input valid, input char_code, input token_end, output ready);
endinterface

`default_nettype wire

// ----- design/adhc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// adhc_rsp_if : answer output channel
// Valid/ready channel carrying one answer character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface adhc_rsp_if ();
   import adhc_pkg::*;

   logic     valid;
   logic     ready;
   char_type out_char;
   logic     out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ----- design/ascii_dec_hex_converter.sv -----
// A character that does not end its token is taken while the engine is idle.
// At a token end, hex-to-decimal runs shift-add-3 over all VALUE_BITS (64) bits in
// the digit engine, decimal-to-hex loads its nibbles directly; a skip over up to 19
// leading zero digits follows, then the answer beats, each held while stalled.
// The input is not ready from a token end until its last answer beat is loaded.
// Reset (synchronous, active high) clears the token state and the halt flag.
// ----------------------------------------------------------------------------
// ascii_dec_hex_converter : decimal / hexadecimal token converter
// Accumulates token characters and hands each token to the engine until halted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_dec_hex_converter_macros.svh"

module ascii_dec_hex_converter (
   input  logic       clock,
   input  logic       reset,
   adhc_req_if.sink   req_chan,
   adhc_rsp_if.source rsp_chan
);
   import adhc_pkg::*;

   localparam int EXT_W = VALUE_BITS + 4;

   function automatic digit_type hex_digit(input char_type c);
      digit_type d;
      d = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = 4'(c - CHAR_UPPER_A) + RADIX_DEC;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = 4'(c - CHAR_LOWER_A) + RADIX_DEC;
      end
      return d;
   endfunction

   value_type  dec_ff, dec_in;
   value_type  hex_ff, hex_in;
   logic [1:0] pos_ff, pos_in;
   logic       sx_ff, sx_in;
   logic       done_ff, done_in;
   logic       halted_ff, halted_in;

   conv_cmd_type cmd;
   logic         eng_busy;
   logic         accept;
   char_type     c;
   logic         is_digit;
   digit_type    dval;
   logic [EXT_W-1:0] dec_prod;
   logic         dec_sat;
   value_type    dec_next, hex_next;
   logic [1:0]   pos_next;
   logic         sx_next, done_next;

   assign req_chan.ready = !eng_busy;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.char_code;

   assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign dval      = 4'(c - CHAR_ZERO);
   assign dec_prod  = ({4'b0, dec_ff} << 3) + ({4'b0, dec_ff} << 1) + EXT_W'(dval);
   assign dec_sat   = dec_prod > EXT_W'(VALUE_SMAX);
   assign dec_next  = (done_ff || !is_digit) ? dec_ff
                    : (dec_sat ? VALUE_SMAX : dec_prod[VALUE_BITS-1:0]);
   assign done_next = done_ff || !is_digit;
   assign hex_next  = (pos_ff >= 2'd2) ? {hex_ff[VALUE_BITS-5:0], hex_digit(c)} : hex_ff;
   assign sx_next   = (pos_ff == 2'd1) ? (c == CHAR_LOWER_X) : sx_ff;
   assign pos_next  = (pos_ff == 2'd3) ? 2'd3 : (pos_ff + 2'd1);

   always_comb begin
      dec_in     = dec_ff;
      hex_in     = hex_ff;
      pos_in     = pos_ff;
      sx_in      = sx_ff;
      done_in    = done_ff;
      halted_in  = halted_ff;
      cmd.start  = 1'b0;
      cmd.to_dec = (pos_next == 2'd3) && sx_next;
      cmd.value  = cmd.to_dec ? hex_next : dec_next;
      if (accept && !halted_ff) begin
         if (pos_ff == 2'd0 && c == CHAR_MINUS) begin
            halted_in = 1'b1;
            dec_in    = '0;
            hex_in    = '0;
            pos_in    = '0;
            sx_in     = 1'b0;
            done_in   = 1'b0;
         end else if (req_chan.token_end) begin
            cmd.start = 1'b1;
            dec_in    = '0;
            hex_in    = '0;
            pos_in    = '0;
            sx_in     = 1'b0;
            done_in   = 1'b0;
         end else begin
            dec_in  = dec_next;
            hex_in  = hex_next;
            pos_in  = pos_next;
            sx_in   = sx_next;
            done_in = done_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff    <= '0;
         hex_ff    <= '0;
         pos_ff    <= '0;
         sx_ff     <= 1'b0;
         done_ff   <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         dec_ff    <= dec_in;
         hex_ff    <= hex_in;
         pos_ff    <= pos_in;
         sx_ff     <= sx_in;
         done_ff   <= done_in;
         halted_ff <= halted_in;
      end
   end

   adhc_digit_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .busy     (eng_busy),
      .rsp_chan (rsp_chan)
   );

   `ADHC_ASSERT_NEXT(a_halt_sticks, clock, reset, halted_ff, halted_ff)
   `ADHC_ASSERT_SAME(a_no_start_halted, clock, reset, halted_ff, !cmd.start)
   `ADHC_ASSERT_NEXT(a_engine_takes_cmd, clock, reset, cmd.start, eng_busy)
   `ADHC_ASSERT_SAME(a_x_flag_early, clock, reset, (pos_ff == 2'd0 || pos_ff == 2'd1), !sx_ff)
   `ADHC_ASSERT_SAME(a_dec_saturated, clock, reset, 1'b1, !dec_ff[VALUE_BITS-1])

endmodule

`default_nettype wire

// ----- design/adhc_digit_engine.sv -----
// ----------------------------------------------------------------------------
// adhc_digit_engine : radix conversion and answer emission
// Shift-add-3 for binary to decimal, nibble load for hex, leading-zero skip,
// 0x prefix for hex and one answer character per beat into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module adhc_digit_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  adhc_pkg::conv_cmd_type cmd,
   output logic                 busy,
   adhc_rsp_if.source           rsp_chan
);
   import adhc_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
   localparam logic [PTR_W-1:0] PTR_TOP  = PTR_W'(NBUF - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DABBLE = 3'd1;
   localparam logic [2:0] ST_SKIP   = 3'd2;
   localparam logic [2:0] ST_PFX0   = 3'd3;
   localparam logic [2:0] ST_PFX1   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]       state_ff, state_in;
   value_type        bin_ff, bin_in;
   digit_type        digit_ff [NBUF];
   digit_type        digit_in [NBUF];
   digit_type        dabble [NBUF];
   digit_type        adjust [NBUF];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             prefix_ff, prefix_in;
   logic             rsp_valid_ff, rsp_valid_in;
   char_type         rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [NBUF*4-1:0] padded;
   digit_type         cur_digit;
   char_type          cur_char;
   logic              out_free;
   logic              load;

   assign padded    = (NBUF*4)'(cmd.value);
   assign cur_digit = digit_ff[ptr_ff];
   assign cur_char  = (cur_digit < RADIX_DEC) ? (CHAR_ZERO + {4'b0, cur_digit})
                                              : (CHAR_UPPER_A + {4'b0, cur_digit - RADIX_DEC});
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // add three to every digit of five or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < NBUF; i++) begin
         adjust[i] = (digit_ff[i] >= 4'd5) ? (digit_ff[i] + 4'd3) : digit_ff[i];
      end
      for (int i = 0; i < NBUF; i++) begin
         if (i == 0) begin
            dabble[i] = {adjust[i][2:0], bin_ff[VALUE_BITS-1]};
         end else begin
            dabble[i] = {adjust[i][2:0], adjust[i-1][3]};
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      bin_in      = bin_ff;
      ptr_in      = ptr_ff;
      cnt_in      = cnt_ff;
      prefix_in   = prefix_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      load        = 1'b0;
      for (int i = 0; i < NBUF; i++) begin
         digit_in[i] = digit_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               prefix_in = !cmd.to_dec;
               ptr_in    = PTR_TOP;
               cnt_in    = '0;
               bin_in    = cmd.value;
               if (cmd.to_dec) begin
                  for (int i = 0; i < NBUF; i++) begin
                     digit_in[i] = '0;
                  end
                  state_in = ST_DABBLE;
               end else begin
                  for (int i = 0; i < NBUF; i++) begin
                     digit_in[i] = padded[4*i +: 4];
                  end
                  state_in = ST_SKIP;
               end
            end
         end
         ST_DABBLE: begin
            for (int i = 0; i < NBUF; i++) begin
               digit_in[i] = dabble[i];
            end
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit == '0 && ptr_ff != '0) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               state_in = prefix_ff ? ST_PFX0 : ST_EMIT;
            end
         end
         ST_PFX0: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_ZERO;
               rsp_last_in = 1'b0;
               state_in    = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_LOWER_X;
               rsp_last_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = cur_char;
               rsp_last_in = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      prefix_ff   <= prefix_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < NBUF; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.out_last = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sim/tb_ascii_dec_hex_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_dec_hex_converter : self-checking bench for the token converter
// Feeds directed and random tokens through the character channel with random
// gaps and back-pressure, predicts each answer beat in-bench and compares.
// ----------------------------------------------------------------------------

module tb_ascii_dec_hex_converter;
   import adhc_pkg::*;

   localparam int       LIMIT_CYCLES = 2000000;
   localparam int       RANDOM_ITEMS = 330;
   localparam int       CALM_ITEMS   = 80;
   localparam int       TAIL_CYCLES  = 300;
   localparam char_type CHAR_SPACE   = 8'h20;

   typedef struct packed {
      char_type code;
      logic     tend;
   } char_beat_type;

   typedef struct packed {
      char_type ch;
      logic     last;
   } answer_beat_type;

   logic clock;
   logic reset;

   adhc_req_if req_bus ();
   adhc_rsp_if rsp_bus ();

   ascii_dec_hex_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   char_beat_type   pending_chars[$];
   answer_beat_type answer_queue[$];
   char_beat_type   next_beat;
   answer_beat_type want;
   int              errors      = 0;
   int              cycle_count = 0;
   int              gap_left    = 0;
   int              stall_left  = 0;

   value_type   dec_acc;
   value_type   hex_acc;
   logic [1:0]  char_pos;
   logic        second_x;
   logic        dec_stopped;
   logic        halted;

   function automatic digit_type hex_nibble(char_type c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return digit_type'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
         return digit_type'(c - CHAR_UPPER_A + 8'd10);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
         return digit_type'(c - CHAR_LOWER_A + 8'd10);
      return '0;
   endfunction

   function automatic char_type digit_char(digit_type d);
      return (d < RADIX_DEC) ? CHAR_ZERO + char_type'(d)
                             : CHAR_UPPER_A + char_type'(d - RADIX_DEC);
   endfunction

   function automatic void clear_token();
      dec_acc     = '0;
      hex_acc     = '0;
      char_pos    = '0;
      second_x    = 1'b0;
      dec_stopped = 1'b0;
   endfunction

   function automatic void put_answer(char_type ch, logic is_last);
      answer_beat_type b;
      b.ch   = ch;
      b.last = is_last;
      answer_queue = {answer_queue, b};
   endfunction

   // Advance the token by one character; unless halted, queue its answer at its end.
   function automatic void convert_char(char_type c, logic tend);
      digit_type digits[NBUF];
      value_type v;
      value_type d;
      logic      to_dec;
      int        n;
      int        i;
      n = 0;
      if (halted) return;
      if (char_pos == 2'd0 && c == CHAR_MINUS) begin
         halted = 1'b1;
         clear_token();
         return;
      end
      if (char_pos == 2'd1) second_x = (c == CHAR_LOWER_X);
      if (char_pos >= 2'd2) hex_acc = {hex_acc[VALUE_BITS-5:0], hex_nibble(c)};
      if (!dec_stopped) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = value_type'(c - CHAR_ZERO);
            if (dec_acc > (VALUE_SMAX - d) / RADIX_DEC) dec_acc = VALUE_SMAX;
            else dec_acc = dec_acc * RADIX_DEC + d;
         end else begin
            dec_stopped = 1'b1;
         end
      end
      if (char_pos != 2'd3) char_pos = char_pos + 2'd1;
      if (!tend) return;
      to_dec = (char_pos == 2'd3) && second_x;
      v = to_dec ? hex_acc : dec_acc;
      if (!to_dec) begin
         put_answer(CHAR_ZERO, 1'b0);
         put_answer(CHAR_LOWER_X, 1'b0);
      end
      do begin
         if (to_dec) begin
            digits[n] = digit_type'(v % RADIX_DEC);
            v = v / RADIX_DEC;
         end else begin
            digits[n] = v[3:0];
            v = v >> 4;
         end
         n++;
      end while (v != 0 && n < (to_dec ? NBUF : NBUF - 2));
      for (i = n - 1; i >= 0; i--) put_answer(digit_char(digits[i]), i == 0);
      clear_token();
   endfunction

   function automatic void put_char(char_type c, logic tend);
      char_beat_type b;
      b.code = c;
      b.tend = tend;
      pending_chars = {pending_chars, b};
   endfunction

   function automatic void put_token(string s);
      int i;
      for (i = 0; i < s.len(); i++) put_char(char_type'(s[i]), i == s.len() - 1);
   endfunction

   // Any byte; a leading one never starts a halt token.
   function automatic char_type junk_char(logic lead);
      char_type c;
      c = char_type'($urandom_range(0, 255));
      if (lead && c == CHAR_MINUS) c = CHAR_SPACE;
      return c;
   endfunction

   task automatic report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_ascii_dec_hex_converter: done, errors");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            convert_char(req_bus.char_code, req_bus.token_end);
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
               next_beat = pending_chars.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.char_code <= next_beat.code;
               req_bus.token_end <= next_beat.tend;
               if (pending_chars.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
                  gap_left = $urandom_range(1, 19);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answer_queue.size() == 0) begin
               report($sformatf("unexpected beat char=%h last=%b",
                                rsp_bus.out_char, rsp_bus.out_last));
            end else begin
               want = answer_queue.pop_front();
               if (rsp_bus.out_char !== want.ch)
                  report($sformatf("out_char got %h want %h", rsp_bus.out_char, want.ch));
               if (rsp_bus.out_last !== want.last)
                  report($sformatf("out_last got %b want %b", rsp_bus.out_last, want.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (pending_chars.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int       directed_n;
      int       kind;
      int       len;
      int       pos;
      char_type c;
      string    hex_set;
      hex_set           = "0123456789abcdefABCDEF";
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.token_end = 1'b0;
      rsp_bus.ready     = 1'b0;
      halted            = 1'b0;
      clear_token();

      put_token("0");
      put_token("123");
      put_token("9223372036854775807");
      put_token("99999999999999999999");
      put_token("0xFFFFFFFFFFFFFFFF");
      put_token("0x0");
      put_token("0xabcDEF");
      put_token("0xg1");
      put_token("0x");
      put_token("1x5");
      put_token("+12");
      put_token("12a34");
      put_token("0X1F");
      put_token("0x1234567890ABCDEF12");
      put_token(" 7");
      put_char(8'hFF, 1'b1);
      put_char(8'h00, 1'b0);
      put_char(CHAR_LOWER_X, 1'b0);
      put_char(CHAR_NINE, 1'b1);
      directed_n = pending_chars.size();

      while (pending_chars.size() < directed_n + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 22) : $urandom_range(1, 6);
         if (kind < 4) begin
            for (pos = 0; pos < len; pos++) begin
               if ($urandom_range(0, 7) == 0) c = junk_char(pos == 0);
               else c = CHAR_ZERO + char_type'($urandom_range(0, 9));
               put_char(c, pos == len - 1);
            end
         end else if (kind < 8) begin
            put_char(($urandom_range(0, 3) == 0) ? junk_char(1'b1) : CHAR_ZERO, 1'b0);
            put_char(CHAR_LOWER_X, 1'b0);
            for (pos = 0; pos < len; pos++) begin
               if ($urandom_range(0, 11) == 0) c = junk_char(1'b0);
               else c = char_type'(hex_set[$urandom_range(0, 21)]);
               put_char(c, pos == len - 1);
            end
         end else begin
            for (pos = 0; pos < len; pos++) put_char(junk_char(pos == 0), pos == len - 1);
         end
      end

      // halt, then characters that must be swallowed
      put_char(CHAR_MINUS, 1'b0);
      put_token("12");
      put_char(CHAR_MINUS, 1'b1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_bus.valid) @(posedge clock);
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0) $display("tb_ascii_dec_hex_converter: done, clean");
      else $display("tb_ascii_dec_hex_converter: done, errors");
      $finish;
   end

endmodule
